// ----- design/dtfd_pkg.sv -----
// Shared types, character codes and field kinds for the TXT field decoder.
// Used by every module of the block; depends on nothing.
`default_nettype none

package dtfd_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned CFG_INDEX_W = 1;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_V     = 8'h56;

    localparam logic [3:0] KIND_UNKNOWN = 4'd0;
    localparam logic [3:0] KIND_D       = 4'd1;
    localparam logic [3:0] KIND_VP      = 4'd2;
    localparam logic [3:0] KIND_AP      = 4'd3;
    localparam logic [3:0] KIND_CM      = 4'd4;
    localparam logic [3:0] KIND_DT      = 4'd5;
    localparam logic [3:0] KIND_DN      = 4'd6;
    localparam logic [3:0] KIND_RI      = 4'd7;
    localparam logic [3:0] KIND_PI      = 4'd8;
    localparam logic [3:0] KIND_PH      = 4'd9;
    localparam logic [3:0] KIND_CRI     = 4'd10;
    localparam logic [3:0] KIND_CRA     = 4'd11;
    localparam logic [3:0] KIND_T       = 4'd12;

    localparam logic [CFG_INDEX_W-1:0] CFG_RETRY_MAX       = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RETRY_UNDEFINED = 1'd1;

    localparam logic [31:0] RETRY_MAX_RESET       = 32'd3600000;
    localparam logic [31:0] RETRY_UNDEFINED_RESET = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       in_value;
        logic       byte_present;
        logic       end_of_entry;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  field_kind;
        logic [31:0] number;
        logic [15:0] product_number;
    } out_item_t;

    // One classified beat as it travels from the front to the back.
    typedef struct packed {
        logic [7:0] ch;
        logic       is_value;
        logic       present;
        logic       last;
        logic       is_digit;
        logic [3:0] digit;
        logic       is_plus;
        logic       is_zero;
        logic       is_one;
    } token_t;

    typedef struct packed {
        logic [31:0] retry_max;
        logic [31:0] retry_undefined;
    } cfg_t;

endpackage

`default_nettype wire

// ----- design/dtfd_front.sv -----
// Front end: accepts input beats, folds case and classifies each byte.
// Depends on dtfd_pkg.
`default_nettype none

module dtfd_front (
    input  wire dtfd_pkg::in_item_t item,
    input  wire logic               item_valid,
    output dtfd_pkg::token_t        token,
    output logic                    token_push
);

    logic [7:0] c;
    logic       lower;

    assign c     = item.data_byte;
    assign lower = (c >= dtfd_pkg::CH_LOW_A) && (c <= dtfd_pkg::CH_LOW_Z);

    always_comb
    begin
        token.ch       = lower ? (c - 8'd32) : c;
        token.is_value = item.in_value;
        token.present  = item.byte_present;
        token.last     = item.end_of_entry;
        token.is_digit = (c >= dtfd_pkg::CH_ZERO) && (c <= dtfd_pkg::CH_NINE);
        token.digit    = 4'(c - dtfd_pkg::CH_ZERO);
        token.is_plus  = (c == dtfd_pkg::CH_PLUS);
        token.is_zero  = (c == dtfd_pkg::CH_ZERO);
        token.is_one   = (c == dtfd_pkg::CH_ONE);
    end

    // A beat that carries neither a byte nor an end mark changes nothing.
    assign token_push = item_valid && (item.byte_present || item.end_of_entry);

endmodule

`default_nettype wire

// ----- design/dtfd_queue.sv -----
// Short token queue between the front and the back of the decoder.
// Depends on dtfd_pkg.
`default_nettype none

module dtfd_queue #(
    parameter int unsigned DEPTH = dtfd_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire dtfd_pkg::token_t push_token,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output dtfd_pkg::token_t      head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    dtfd_pkg::token_t store [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= push_token;
        end
    end

endmodule

`default_nettype wire

// ----- design/dtfd_back.sv -----
// Back end: keeps the per-entry key and number state, and at the end of an
// entry turns a snapshot of it into a result. Depends on dtfd_pkg.
`default_nettype none

module dtfd_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dtfd_pkg::cfg_t    cfg,
    input  wire logic              tok_valid,
    input  wire dtfd_pkg::token_t  tok,
    output logic                   tok_pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output dtfd_pkg::out_item_t    out_data
);

    // Per-entry state.
    logic [7:0]  key0_reg, key1_reg, key2_reg;
    logic [2:0]  key_len_reg;
    logic [31:0] acc_reg;
    logic [3:0]  part_len_reg;
    logic        lead_reg, bad_reg, ovf_reg;
    logic [15:0] vendor_reg;
    logic        after_plus_reg;
    logic [1:0]  single_one_reg;

    // State after the current beat.
    logic [7:0]  key0_next, key1_next, key2_next;
    logic [2:0]  key_len_next;
    logic [31:0] acc_next;
    logic [3:0]  part_len_next;
    logic        lead_next, bad_next, ovf_next;
    logic [15:0] vendor_next;
    logic        after_plus_next;
    logic [1:0]  single_one_next;

    // Snapshot of a finished entry, evaluated in the following stage.
    logic        snap_valid_reg;
    logic [7:0]  s_key0_reg, s_key1_reg, s_key2_reg;
    logic [2:0]  s_key_len_reg;
    logic [31:0] s_acc_reg;
    logic [3:0]  s_part_len_reg;
    logic        s_lead_reg, s_bad_reg, s_ovf_reg;
    logic [15:0] s_vendor_reg;
    logic        s_after_plus_reg;
    logic [1:0]  s_single_one_reg;

    logic                out_valid_reg;
    dtfd_pkg::out_item_t out_data_reg, out_data_next;

    logic        out_can_take, snap_free, take;
    logic        key_is_vp, cur_valid;
    logic [35:0] times_ten;

    function automatic logic part_ok(input logic [3:0] len, input logic lead,
                                     input logic bad, input logic ovf);
        logic ok;
        begin
            ok = (len != 4'd0) && (len <= 4'd10) && !(len > 4'd1 && lead) && !bad && !ovf;
            return ok;
        end
    endfunction

    assign out_can_take = !out_valid_reg || !out_stall;
    assign snap_free    = !snap_valid_reg || out_can_take;
    assign take         = tok_valid && (!tok.last || snap_free);
    assign tok_pop      = take;

    assign key_is_vp = (key_len_reg == 3'd2) && (key0_reg == dtfd_pkg::CH_V)
                       && (key1_reg == dtfd_pkg::CH_P);
    assign cur_valid = part_ok(part_len_reg, lead_reg, bad_reg, ovf_reg);
    assign times_ten = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) + 36'(tok.digit);

    always_comb
    begin
        key0_next       = key0_reg;
        key1_next       = key1_reg;
        key2_next       = key2_reg;
        key_len_next    = key_len_reg;
        acc_next        = acc_reg;
        part_len_next   = part_len_reg;
        lead_next       = lead_reg;
        bad_next        = bad_reg;
        ovf_next        = ovf_reg;
        vendor_next     = vendor_reg;
        after_plus_next = after_plus_reg;
        single_one_next = single_one_reg;
        if (tok.present)
        begin
            if (tok.is_value)
            begin
                single_one_next = (single_one_reg == 2'd0 && tok.is_one) ? 2'd1 : 2'd2;
                if (tok.is_plus && !after_plus_reg && key_is_vp)
                begin
                    vendor_next     = (cur_valid && acc_reg[31:16] == 16'd0) ?
                                      acc_reg[15:0] : 16'd0;
                    acc_next        = '0;
                    part_len_next   = '0;
                    lead_next       = 1'b0;
                    bad_next        = 1'b0;
                    ovf_next        = 1'b0;
                    after_plus_next = 1'b1;
                end
                else
                begin
                    if (part_len_reg == 4'd0 && tok.is_zero)
                    begin
                        lead_next = 1'b1;
                    end
                    if (tok.is_digit)
                    begin
                        acc_next = times_ten[31:0];
                        if (times_ten[35:32] != 4'd0)
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else
                    begin
                        bad_next = 1'b1;
                    end
                    if (part_len_reg < 4'd11)
                    begin
                        part_len_next = part_len_reg + 4'd1;
                    end
                end
            end
            else
            begin
                unique case (key_len_reg)
                    3'd0:    key0_next = tok.ch;
                    3'd1:    key1_next = tok.ch;
                    3'd2:    key2_next = tok.ch;
                    default: ;
                endcase
                if (key_len_reg < 3'd4)
                begin
                    key_len_next = key_len_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg       <= '0;
            key1_reg       <= '0;
            key2_reg       <= '0;
            key_len_reg    <= '0;
            acc_reg        <= '0;
            part_len_reg   <= '0;
            lead_reg       <= 1'b0;
            bad_reg        <= 1'b0;
            ovf_reg        <= 1'b0;
            vendor_reg     <= '0;
            after_plus_reg <= 1'b0;
            single_one_reg <= '0;
            snap_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (take && tok.last)
            begin
                key0_reg       <= '0;
                key1_reg       <= '0;
                key2_reg       <= '0;
                key_len_reg    <= '0;
                acc_reg        <= '0;
                part_len_reg   <= '0;
                lead_reg       <= 1'b0;
                bad_reg        <= 1'b0;
                ovf_reg        <= 1'b0;
                vendor_reg     <= '0;
                after_plus_reg <= 1'b0;
                single_one_reg <= '0;
            end
            else if (take)
            begin
                key0_reg       <= key0_next;
                key1_reg       <= key1_next;
                key2_reg       <= key2_next;
                key_len_reg    <= key_len_next;
                acc_reg        <= acc_next;
                part_len_reg   <= part_len_next;
                lead_reg       <= lead_next;
                bad_reg        <= bad_next;
                ovf_reg        <= ovf_next;
                vendor_reg     <= vendor_next;
                after_plus_reg <= after_plus_next;
                single_one_reg <= single_one_next;
            end

            if (take && tok.last)
            begin
                snap_valid_reg <= 1'b1;
            end
            else if (out_can_take)
            begin
                snap_valid_reg <= 1'b0;
            end

            if (snap_valid_reg && out_can_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && tok.last)
        begin
            s_key0_reg       <= key0_next;
            s_key1_reg       <= key1_next;
            s_key2_reg       <= key2_next;
            s_key_len_reg    <= key_len_next;
            s_acc_reg        <= acc_next;
            s_part_len_reg   <= part_len_next;
            s_lead_reg       <= lead_next;
            s_bad_reg        <= bad_next;
            s_ovf_reg        <= ovf_next;
            s_vendor_reg     <= vendor_next;
            s_after_plus_reg <= after_plus_next;
            s_single_one_reg <= single_one_next;
        end
        if (snap_valid_reg && out_can_take)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Result stage: key lookup, strict-number check and narrowing.
    logic [3:0]  kind;
    logic        s_valid;
    logic [31:0] s_u32;
    logic [15:0] s_u16;

    always_comb
    begin
        priority if (s_key_len_reg == 3'd1 && s_key0_reg == dtfd_pkg::CH_D)
            kind = dtfd_pkg::KIND_D;
        else if (s_key_len_reg == 3'd2 && s_key0_reg == dtfd_pkg::CH_V
                 && s_key1_reg == dtfd_pkg::CH_P)
            kind = dtfd_pkg::KIND_VP;
        else if (s_key_len_reg == 3'd2 && s_key0_reg == dtfd_pkg::CH_A
                 && s_key1_reg == dtfd_pkg::CH_P)
            kind = dtfd_pkg::KIND_AP;
        else if (s_key_len_reg == 3'd2 && s_key0_reg == dtfd_pkg::CH_C
                 && s_key1_reg == dtfd_pkg::CH_M)
            kind = dtfd_pkg::KIND_CM;
        else if (s_key_len_reg == 3'd2 && s_key0_reg == dtfd_pkg::CH_D
                 && s_key1_reg == dtfd_pkg::CH_T)
            kind = dtfd_pkg::KIND_DT;
        else if (s_key_len_reg == 3'd2 && s_key0_reg == dtfd_pkg::CH_D
                 && s_key1_reg == dtfd_pkg::CH_N)
            kind = dtfd_pkg::KIND_DN;
        else if (s_key_len_reg == 3'd2 && s_key0_reg == dtfd_pkg::CH_R
                 && s_key1_reg == dtfd_pkg::CH_I)
            kind = dtfd_pkg::KIND_RI;
        else if (s_key_len_reg == 3'd2 && s_key0_reg == dtfd_pkg::CH_P
                 && s_key1_reg == dtfd_pkg::CH_I)
            kind = dtfd_pkg::KIND_PI;
        else if (s_key_len_reg == 3'd2 && s_key0_reg == dtfd_pkg::CH_P
                 && s_key1_reg == dtfd_pkg::CH_H)
            kind = dtfd_pkg::KIND_PH;
        else if (s_key_len_reg == 3'd3 && s_key0_reg == dtfd_pkg::CH_C
                 && s_key1_reg == dtfd_pkg::CH_R && s_key2_reg == dtfd_pkg::CH_I)
            kind = dtfd_pkg::KIND_CRI;
        else if (s_key_len_reg == 3'd3 && s_key0_reg == dtfd_pkg::CH_C
                 && s_key1_reg == dtfd_pkg::CH_R && s_key2_reg == dtfd_pkg::CH_A)
            kind = dtfd_pkg::KIND_CRA;
        else if (s_key_len_reg == 3'd1 && s_key0_reg == dtfd_pkg::CH_T)
            kind = dtfd_pkg::KIND_T;
        else
            kind = dtfd_pkg::KIND_UNKNOWN;
    end

    assign s_valid = part_ok(s_part_len_reg, s_lead_reg, s_bad_reg, s_ovf_reg);
    assign s_u32   = s_valid ? s_acc_reg : 32'd0;
    assign s_u16   = (s_u32[31:16] == 16'd0) ? s_u32[15:0] : 16'd0;

    always_comb
    begin
        out_data_next.field_kind     = kind;
        out_data_next.number         = 32'd0;
        out_data_next.product_number = 16'd0;
        unique case (kind)
            dtfd_pkg::KIND_D, dtfd_pkg::KIND_DT, dtfd_pkg::KIND_PH:
                out_data_next.number = {16'd0, s_u16};
            dtfd_pkg::KIND_VP:
            begin
                if (s_after_plus_reg)
                begin
                    out_data_next.number         = {16'd0, s_vendor_reg};
                    out_data_next.product_number = s_u16;
                end
                else
                begin
                    out_data_next.number = {16'd0, s_u16};
                end
            end
            dtfd_pkg::KIND_AP, dtfd_pkg::KIND_CM:
                out_data_next.number = (s_u32[31:8] == 24'd0) ? s_u32 : 32'd0;
            dtfd_pkg::KIND_CRI, dtfd_pkg::KIND_CRA:
                out_data_next.number = (s_valid && s_acc_reg != cfg.retry_undefined
                                        && s_acc_reg <= cfg.retry_max) ?
                                       s_acc_reg : cfg.retry_undefined;
            dtfd_pkg::KIND_T:
                out_data_next.number = {31'd0, s_single_one_reg == 2'd1};
            default:
                out_data_next.number = 32'd0;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ----- design/dns_txt_field_decoder_core.sv -----
// DNS TXT entry field decoder, top level: configuration registers, front,
// token queue and back. Depends on dtfd_pkg, dtfd_front, dtfd_queue, dtfd_back.
//
// Usage: each TXT entry is sent as a sequence of beats on the input channel,
// key bytes (in_value low) then value bytes, the last beat with end_of_entry
// set. One result beat (field kind, number, product number) comes out per
// entry. Both channels use valid/stall; a beat moves on an edge with valid
// high and stall low.
// Throughput: one input beat per cycle while the queue is not full. The back end
// retires one queued beat per cycle, carrying the decimal accumulate (times ten
// plus digit) combinationally, but holds a closing beat while the snapshot and
// the result register are both full and the receiver stalls. With the queue
// empty, a closing beat is written into the queue, then captured in the
// snapshot, then loaded into the result register.
// When the receiver stalls, the result register and a snapshot stage hold two
// results; the back end then stops at the next closing beat, the queue fills
// and in_stall rises once it is full.
// Reset clears all entry state, the queue and both output stages, and loads
// retry_max with 3600000 and retry_undefined with all ones. The config port
// is always ready; writes are meant to happen while the block is idle.
`default_nettype none

module dns_txt_field_decoder_core #(
    parameter int unsigned QUEUE_DEPTH = dtfd_pkg::QUEUE_DEPTH
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire dtfd_pkg::in_item_t               in_data,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output dtfd_pkg::out_item_t                   out_data,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [dtfd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]                      cfg_data
);

    dtfd_pkg::cfg_t   cfg_reg;
    dtfd_pkg::token_t front_token, head_token;
    logic             front_push, queue_full, queue_not_empty, back_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.retry_max       <= dtfd_pkg::RETRY_MAX_RESET;
            cfg_reg.retry_undefined <= dtfd_pkg::RETRY_UNDEFINED_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dtfd_pkg::CFG_RETRY_MAX:       cfg_reg.retry_max       <= cfg_data;
                dtfd_pkg::CFG_RETRY_UNDEFINED: cfg_reg.retry_undefined <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_stall = queue_full;

    dtfd_front u_front (
        .item       (in_data),
        .item_valid (in_valid && !in_stall),
        .token      (front_token),
        .token_push (front_push)
    );

    dtfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_push),
        .push_token (front_token),
        .full       (queue_full),
        .pop        (back_pop),
        .not_empty  (queue_not_empty),
        .head       (head_token)
    );

    dtfd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .tok_valid (queue_not_empty),
        .tok       (head_token),
        .tok_pop   (back_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Only VP entries carry a product number.
    a_product_only_vp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.field_kind != dtfd_pkg::KIND_VP
        |-> out_data.product_number == 16'd0)
        else $error("product number set on a non-VP result");

    // AP and CM results are narrowed to eight bits.
    a_narrow_eight: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.field_kind == dtfd_pkg::KIND_AP
                      || out_data.field_kind == dtfd_pkg::KIND_CM)
        |-> out_data.number[31:8] == 24'd0)
        else $error("AP or CM result wider than eight bits");

    // The T flag is a single bit.
    a_flag_bit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.field_kind == dtfd_pkg::KIND_T
        |-> out_data.number[31:1] == 31'd0)
        else $error("T result is not zero or one");

endmodule

`default_nettype wire

// ----- bench/txt_field_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the DNS TXT field decoder: follows the beat, result and
// register channels, predicts every result and compares it. Needs dtfd_pkg.

module txt_field_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    input  wire logic                             in_stall,
    input  wire dtfd_pkg::in_item_t               in_data,
    input  wire logic                             out_valid,
    input  wire logic                             out_stall,
    input  wire dtfd_pkg::out_item_t              out_data,
    input  wire logic                             cfg_valid,
    input  wire logic                             cfg_ready,
    input  wire logic [dtfd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]                      cfg_data,
    output int                                    fields_pending,
    output int                                    mismatch_count,
    output int                                    results_checked
);

    // Entry state as the decoder should hold it.
    logic [7:0]  key_chars [3];
    logic [2:0]  key_len;
    logic [31:0] acc;
    logic [3:0]  part_len;
    logic        lead_zero;
    logic        bad_char;
    logic        overflow;
    logic [15:0] vendor;
    logic        after_plus;
    logic [1:0]  single_one;

    logic [31:0] lim_max;
    logic [31:0] lim_undef;

    dtfd_pkg::out_item_t expected_fields [$];
    int                  mismatches;
    int                  checked;

    function automatic logic [7:0] upper(input logic [7:0] c);
        return (c >= dtfd_pkg::CH_LOW_A && c <= dtfd_pkg::CH_LOW_Z) ? c - 8'd32 : c;
    endfunction

    function automatic logic [3:0] key_kind();
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [3:0] kind;
        c0 = upper(key_chars[0]);
        c1 = upper(key_chars[1]);
        c2 = upper(key_chars[2]);
        kind = dtfd_pkg::KIND_UNKNOWN;
        if (key_len == 3'd1)
        begin
            if (c0 == dtfd_pkg::CH_D)
                kind = dtfd_pkg::KIND_D;
            else if (c0 == dtfd_pkg::CH_T)
                kind = dtfd_pkg::KIND_T;
        end
        else if (key_len == 3'd2)
        begin
            case ({c0, c1})
                {dtfd_pkg::CH_V, dtfd_pkg::CH_P}: kind = dtfd_pkg::KIND_VP;
                {dtfd_pkg::CH_A, dtfd_pkg::CH_P}: kind = dtfd_pkg::KIND_AP;
                {dtfd_pkg::CH_C, dtfd_pkg::CH_M}: kind = dtfd_pkg::KIND_CM;
                {dtfd_pkg::CH_D, dtfd_pkg::CH_T}: kind = dtfd_pkg::KIND_DT;
                {dtfd_pkg::CH_D, dtfd_pkg::CH_N}: kind = dtfd_pkg::KIND_DN;
                {dtfd_pkg::CH_R, dtfd_pkg::CH_I}: kind = dtfd_pkg::KIND_RI;
                {dtfd_pkg::CH_P, dtfd_pkg::CH_I}: kind = dtfd_pkg::KIND_PI;
                {dtfd_pkg::CH_P, dtfd_pkg::CH_H}: kind = dtfd_pkg::KIND_PH;
                default: kind = dtfd_pkg::KIND_UNKNOWN;
            endcase
        end
        else if (key_len == 3'd3)
        begin
            if ({c0, c1, c2} == {dtfd_pkg::CH_C, dtfd_pkg::CH_R, dtfd_pkg::CH_I})
                kind = dtfd_pkg::KIND_CRI;
            else if ({c0, c1, c2} == {dtfd_pkg::CH_C, dtfd_pkg::CH_R, dtfd_pkg::CH_A})
                kind = dtfd_pkg::KIND_CRA;
        end
        return kind;
    endfunction

    // A number is good with 1 to 10 digits only, no leading zero unless it is the only digit, and no overflow.
    function automatic logic part_ok();
        return part_len != 4'd0 && part_len <= 4'd10 && !(part_len > 4'd1 && lead_zero)
               && !bad_char && !overflow;
    endfunction

    function automatic logic [31:0] part_u32();
        return part_ok() ? acc : 32'd0;
    endfunction

    function automatic logic [15:0] part_u16();
        logic [31:0] v;
        v = part_u32();
        return (v <= 32'h0000_FFFF) ? v[15:0] : 16'd0;
    endfunction

    function automatic void clear_part();
        acc = 32'd0;
        part_len = 4'd0;
        lead_zero = 1'b0;
        bad_char = 1'b0;
        overflow = 1'b0;
    endfunction

    function automatic void clear_entry();
        key_chars[0] = 8'd0;
        key_chars[1] = 8'd0;
        key_chars[2] = 8'd0;
        key_len = 3'd0;
        clear_part();
        vendor = 16'd0;
        after_plus = 1'b0;
        single_one = 2'd0;
    endfunction

    function automatic void take_value_char(input logic [7:0] c);
        logic [35:0] wide;
        logic [7:0]  d;
        single_one = (single_one == 2'd0 && c == dtfd_pkg::CH_ONE) ? 2'd1 : 2'd2;
        if (c == dtfd_pkg::CH_PLUS && !after_plus && key_kind() == dtfd_pkg::KIND_VP)
        begin
            vendor = part_u16();
            clear_part();
            after_plus = 1'b1;
        end
        else
        begin
            if (part_len == 4'd0 && c == dtfd_pkg::CH_ZERO)
                lead_zero = 1'b1;
            if (c >= dtfd_pkg::CH_ZERO && c <= dtfd_pkg::CH_NINE)
            begin
                d = c - dtfd_pkg::CH_ZERO;
                wide = {4'd0, acc} * 36'd10 + {28'd0, d};
                if (wide[35:32] != 4'd0)
                    overflow = 1'b1;
                acc = wide[31:0];
            end
            else
                bad_char = 1'b1;
            if (part_len < 4'd11)
                part_len = part_len + 4'd1;
        end
    endfunction

    function automatic void decode_beat(input dtfd_pkg::in_item_t b);
        dtfd_pkg::out_item_t res;
        logic [31:0]         v;
        if (b.byte_present)
        begin
            if (b.in_value)
                take_value_char(b.data_byte);
            else
            begin
                if (key_len < 3'd3)
                    key_chars[key_len[1:0]] = b.data_byte;
                if (key_len < 3'd4)
                    key_len = key_len + 3'd1;
            end
        end
        if (b.end_of_entry)
        begin
            res.field_kind = key_kind();
            res.number = 32'd0;
            res.product_number = 16'd0;
            case (res.field_kind)
                dtfd_pkg::KIND_D, dtfd_pkg::KIND_DT, dtfd_pkg::KIND_PH:
                    res.number = {16'd0, part_u16()};
                dtfd_pkg::KIND_VP:
                begin
                    if (after_plus)
                    begin
                        res.number = {16'd0, vendor};
                        res.product_number = part_u16();
                    end
                    else
                        res.number = {16'd0, part_u16()};
                end
                dtfd_pkg::KIND_AP, dtfd_pkg::KIND_CM:
                begin
                    v = part_u32();
                    res.number = (v <= 32'd255) ? v : 32'd0;
                end
                dtfd_pkg::KIND_CRI, dtfd_pkg::KIND_CRA:
                begin
                    v = acc;
                    if (part_ok() && v != lim_undef && v <= lim_max)
                        res.number = v;
                    else
                        res.number = lim_undef;
                end
                dtfd_pkg::KIND_T:
                    res.number = (single_one == 2'd1) ? 32'd1 : 32'd0;
                default:
                    res.number = 32'd0;
            endcase
            expected_fields.push_back(res);
            clear_entry();
        end
    endfunction

    function automatic void check_result(input dtfd_pkg::out_item_t got);
        dtfd_pkg::out_item_t want;
        if (expected_fields.size() == 0)
        begin
            $display("%0t: result with nothing expected: kind %0d number %0d product %0d",
                     $time, got.field_kind, got.number, got.product_number);
            mismatches++;
        end
        else
        begin
            want = expected_fields.pop_front();
            checked++;
            if (got.field_kind !== want.field_kind)
            begin
                $display("%0t: field_kind expected %0d actual %0d",
                         $time, want.field_kind, got.field_kind);
                mismatches++;
            end
            if (got.number !== want.number)
            begin
                $display("%0t: number expected %0d actual %0d (kind %0d)",
                         $time, want.number, got.number, want.field_kind);
                mismatches++;
            end
            if (got.product_number !== want.product_number)
            begin
                $display("%0t: product_number expected %0d actual %0d",
                         $time, want.product_number, got.product_number);
                mismatches++;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_entry();
            lim_max = dtfd_pkg::RETRY_MAX_RESET;
            lim_undef = dtfd_pkg::RETRY_UNDEFINED_RESET;
            expected_fields.delete();
            mismatches = 0;
            checked = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    dtfd_pkg::CFG_RETRY_MAX:       lim_max = cfg_data;
                    dtfd_pkg::CFG_RETRY_UNDEFINED: lim_undef = cfg_data;
                    default: ;
                endcase
            end
            // A result leaving at this edge was formed before this edge's beat.
            if (out_valid && !out_stall)
                check_result(out_data);
            if (in_valid && !in_stall)
                decode_beat(in_data);
        end
        fields_pending <= expected_fields.size();
        mismatch_count <= mismatches;
        results_checked <= checked;
    end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// Top of the DNS TXT field decoder bench: clock, reset, entry stimulus and
// register writes. Needs dtfd_pkg, txt_field_checker and the decoder RTL.

module tb;

    localparam int PHASE_BEATS   = 50;
    localparam int HOLD_CYCLES   = 150;
    localparam int SETTLE_CYCLES = 12;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam int KEY_VP = 1;
    localparam int KEY_T  = 11;

    typedef logic [7:0] bytes_t [$];

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    dtfd_pkg::in_item_t               in_data = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    dtfd_pkg::out_item_t              out_data;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [dtfd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0]                      cfg_data = '0;

    int fields_pending;
    int mismatch_count;
    int results_checked;

    string  key_names [12] = '{"D", "VP", "AP", "CM", "DT", "DN", "RI", "PI", "PH",
                               "CRI", "CRA", "T"};
    bytes_t no_bytes;
    logic [31:0] cur_max;
    logic [31:0] cur_undef;
    bit     in_gaps_on = 1'b1;
    bit     rx_quiet = 1'b0;
    bit     hold_request = 1'b0;
    int     holds_done = 0;
    int     beats_sent = 0;
    int     entries_sent = 0;
    int     settings_used = 1;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    dns_txt_field_decoder_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    txt_field_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_data        (out_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fields_pending  (fields_pending),
        .mismatch_count  (mismatch_count),
        .results_checked (results_checked)
    );

    initial
    begin
        #2_000_000;
        $display("dns_txt_field_decoder_core test failed");
        $finish;
    end

    function automatic dtfd_pkg::in_item_t make_beat(input logic [7:0] c, input logic v,
                                                     input logic p, input logic e);
        dtfd_pkg::in_item_t b;
        b.data_byte = c;
        b.in_value = v;
        b.byte_present = p;
        b.end_of_entry = e;
        return b;
    endfunction

    function automatic bytes_t to_bytes(input string s);
        bytes_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    function automatic bytes_t dec_bytes(input logic [63:0] n);
        bytes_t q;
        logic [7:0] d;
        if (n == 64'd0)
            q.push_back(dtfd_pkg::CH_ZERO);
        while (n != 64'd0)
        begin
            d = 8'(n % 64'd10);
            q.push_front(dtfd_pkg::CH_ZERO + d);
            n = n / 64'd10;
        end
        return q;
    endfunction

    // Values cluster on the narrowing edges and on the current retry limits.
    function automatic logic [63:0] pick_number();
        logic [63:0] n;
        case ($urandom_range(0, 9))
            0: n = 64'($urandom_range(0, 9));
            1: n = 64'($urandom_range(10, 255));
            2: n = 64'($urandom_range(256, 65535));
            3: n = 64'd65535 + 64'($urandom_range(0, 1));
            4: n = {32'd0, $urandom};
            5: n = 64'hFFFF_FFFF + 64'($urandom_range(0, 1));
            6: n = {32'd0, cur_max} + 64'($urandom_range(0, 2)) - 64'd1;
            7: n = {32'd0, cur_undef};
            8: n = 64'd1_000_000_000 + ({$urandom, $urandom} % 64'd9_000_000_000);
            default: n = 64'd0;
        endcase
        return n;
    endfunction

    function automatic bytes_t mangle(input bytes_t v);
        int pos;
        case ($urandom_range(0, 5))
            0: v.push_front(dtfd_pkg::CH_ZERO);
            1:
            begin
                if (v.size() == 0)
                    v.push_back(8'($urandom_range(0, 255)));
                else
                begin
                    pos = $urandom_range(0, v.size() - 1);
                    v[pos] = 8'($urandom_range(0, 255));
                end
            end
            2: v.push_front($urandom_range(0, 1) ? dtfd_pkg::CH_PLUS : CH_MINUS);
            3:
            begin
                if ($urandom_range(0, 1))
                    v.push_front(CH_SPACE);
                else
                    v.push_back(CH_SPACE);
            end
            4: v.delete();
            default:
            begin
                while (v.size() < 11)
                    v.push_back(dtfd_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            end
        endcase
        return v;
    endfunction

    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (!in_gaps_on || r < 75)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 25);
    endfunction

    task automatic push_beat(input dtfd_pkg::in_item_t b);
        int gap;
        gap = gap_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Key beats, then value beats, then any late key beats; the entry is closed
    // on its last byte or by a separate beat that carries no byte.
    task automatic send_entry(input bytes_t key, input bytes_t val, input bytes_t late,
                              input bit end_on_byte);
        dtfd_pkg::in_item_t beats [$];
        dtfd_pkg::in_item_t b;
        foreach (key[i])
            beats.push_back(make_beat(key[i], 1'b0, 1'b1, 1'b0));
        foreach (val[i])
            beats.push_back(make_beat(val[i], 1'b1, 1'b1, 1'b0));
        foreach (late[i])
            beats.push_back(make_beat(late[i], 1'b0, 1'b1, 1'b0));
        if (end_on_byte && beats.size() != 0)
        begin
            b = beats.pop_back();
            b.end_of_entry = 1'b1;
            beats.push_back(b);
        end
        else
            beats.push_back(make_beat(8'($urandom_range(0, 255)),
                                      1'($urandom_range(0, 1)), 1'b0, 1'b1));
        foreach (beats[i])
        begin
            if ($urandom_range(0, 19) == 0)
                push_beat(make_beat(8'($urandom_range(0, 255)),
                                    1'($urandom_range(0, 1)), 1'b0, 1'b0));
            push_beat(beats[i]);
        end
        beats_sent += beats.size();
        entries_sent++;
    endtask

    task automatic send_text(input string key, input string val, input bit end_on_byte);
        send_entry(to_bytes(key), to_bytes(val), no_bytes, end_on_byte);
    endtask

    task automatic run_directed();
        bytes_t val;
        send_text("D", "0", 1'b1);
        send_text("d", "65535", 1'b1);
        send_text("D", "65536", 1'b1);
        send_text("VP", "65521+32768", 1'b1);
        send_text("vp", "123", 1'b1);
        send_text("VP", "", 1'b0);
        send_text("Vp", "+5", 1'b1);
        send_text("VP", "1+2+3", 1'b1);
        send_text("AP", "256", 1'b1);
        send_text("cm", "255", 1'b1);
        send_text("DT", "007", 1'b1);
        send_text("DN", "abc", 1'b1);
        send_text("PH", "4294967295", 1'b1);
        send_text("CRI", "4294967296", 1'b1);
        send_text("CRA", "3600000", 1'b1);
        send_text("cri", "3600001", 1'b1);
        send_text("CRA", "12345678901", 1'b1);
        send_text("CRI", "4294967295", 1'b1);
        send_text("cRi", "", 1'b0);
        send_text("T", "1", 1'b1);
        send_text("t", "11", 1'b1);
        send_text("ABCD", "1", 1'b1);
        send_text("", "5", 1'b1);
        send_text("D", "+5", 1'b1);
        send_text("D", " 5", 1'b1);
        val = to_bytes("5");
        val.push_back(8'h00);
        send_entry(to_bytes("D"), val, no_bytes, 1'b1);
        // The plus arrives while the key is still one character long.
        send_entry(to_bytes("V"), to_bytes("5+"), to_bytes("P"), 1'b1);
    endtask

    task automatic random_entry();
        bytes_t key;
        bytes_t val;
        bytes_t tail;
        bytes_t late;
        int idx;
        int n;
        idx = -1;
        if ($urandom_range(0, 99) < 85)
        begin
            idx = $urandom_range(0, 11);
            key = to_bytes(key_names[idx]);
            foreach (key[i])
                if ($urandom_range(0, 1))
                    key[i] = key[i] | 8'h20;
        end
        else
        begin
            n = $urandom_range(0, 5);
            repeat (n) key.push_back(8'($urandom_range(0, 255)));
        end
        if (idx == KEY_VP && $urandom_range(0, 3) != 0)
        begin
            val = dec_bytes(pick_number() & 64'h1_FFFF);
            val.push_back(dtfd_pkg::CH_PLUS);
            tail = dec_bytes(pick_number());
            if ($urandom_range(0, 5) == 0)
            begin
                tail.push_back(dtfd_pkg::CH_PLUS);
                tail.push_back(dtfd_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            end
            foreach (tail[i])
                val.push_back(tail[i]);
        end
        else if (idx == KEY_T)
        begin
            case ($urandom_range(0, 4))
                0: val = to_bytes("1");
                1: val = to_bytes("0");
                2: val = to_bytes("11");
                3: val.delete();
                default: val.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        else
            val = dec_bytes(pick_number());
        if ($urandom_range(0, 4) == 0)
            val = mangle(val);
        if ($urandom_range(0, 19) == 0)
            late.push_back(8'($urandom_range(dtfd_pkg::CH_A, CH_UP_Z)));
        send_entry(key, val, late, $urandom_range(0, 3) != 0);
    endtask

    task automatic random_phase();
        int start;
        start = beats_sent;
        while (beats_sent - start < PHASE_BEATS)
            random_entry();
    endtask

    // Waits for every predicted result and for beats still queued inside.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (fields_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [31:0] rmax, input logic [31:0] rundef);
        cfg_index <= dtfd_pkg::CFG_RETRY_MAX;
        cfg_data <= rmax;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= dtfd_pkg::CFG_RETRY_UNDEFINED;
        cfg_data <= rundef;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_max = rmax;
        cur_undef = rundef;
        settings_used++;
    endtask

    // Receiver: random stalls, calm stretches, and one long hold-off on request.
    initial
    begin
        int r;
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                holds_done++;
            end
            else if (rx_quiet)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    out_stall <= 1'b0;
                    repeat ($urandom_range(1, 4)) @(posedge clk);
                end
                else if (r < 92)
                begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                end
                else
                begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(5, 30)) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        logic [31:0] rmax;
        logic [31:0] rundef;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        cur_max = dtfd_pkg::RETRY_MAX_RESET;
        cur_undef = dtfd_pkg::RETRY_UNDEFINED_RESET;
        run_directed();
        settle();
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    rmax = 32'd0;
                    rundef = 32'd0;
                end
                1:
                begin
                    rmax = 32'hFFFF_FFFF;
                    rundef = 32'hFFFF_FFFF;
                end
                2:
                begin
                    rmax = dtfd_pkg::RETRY_MAX_RESET;
                    rundef = dtfd_pkg::RETRY_UNDEFINED_RESET;
                end
                3:
                begin
                    rmax = 32'hFFFF_FFFF;
                    rundef = 32'd0;
                end
                4:
                begin
                    rmax = 32'd0;
                    rundef = 32'hFFFF_FFFF;
                end
                default:
                begin
                    rmax = $urandom_range(0, 5_000_000);
                    rundef = $urandom;
                end
            endcase
            apply_settings(rmax, rundef);
            // Phase 1 runs with no idling at all; phase 2 floods the block while
            // the receiver holds off.
            in_gaps_on = (p != 1 && p != 2);
            rx_quiet = (p == 1);
            hold_request = (p == 2);
            random_phase();
            settle();
        end
        $display("Covered %0d entries in %0d beats under %0d retry register settings,",
                 entries_sent, beats_sent, settings_used);
        $display("with %0d long receiver hold-off(s); %0d results compared.",
                 holds_done, results_checked);
        if (mismatch_count == 0)
            $display("dns_txt_field_decoder_core test passed");
        else
            $display("dns_txt_field_decoder_core test failed");
        $finish;
    end

endmodule

// ----- files.f -----
design/dtfd_pkg.sv
design/dtfd_front.sv
design/dtfd_queue.sv
design/dtfd_back.sv
design/dns_txt_field_decoder_core.sv
bench/txt_field_checker.sv
bench/tb.sv
